>>> hw/rtl/descriptor_allocator_lifo_core_assert.svh
// Concurrent assertion macros used by the allocator core RTL.
`ifndef DESCRIPTOR_ALLOCATOR_LIFO_CORE_ASSERT_SVH
`define DESCRIPTOR_ALLOCATOR_LIFO_CORE_ASSERT_SVH

`ifndef SYNTH

`define DAL_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("allocator assertion failed");

`define DAL_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("allocator forbidden condition seen");

`else

`define DAL_ASSERT(label, clk, rstn, prop)

`define DAL_ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

>>> hw/rtl/dal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dal_pkg;

    localparam int NUM_W        = 8;
    localparam int HANDLE_W     = 64;
    localparam int FIRST_NUMBER = 3;
    localparam int CAPACITY     = 16;
    localparam int LIMIT        = FIRST_NUMBER + CAPACITY;
    localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic [1:0] STREAM_NONE = 2'd0;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [NUM_W-1:0]    desc_num;
        logic [HANDLE_W-1:0] handle_in;
    } in_item_t;

    typedef struct packed {
        logic                status;
        logic [NUM_W-1:0]    desc_out;
        logic [HANDLE_W-1:0] handle_out;
        logic [1:0]          std_stream;
    } out_item_t;

    function automatic logic in_range(input logic [NUM_W-1:0] n);
        return (int'(n) >= FIRST_NUMBER) && (int'(n) < LIMIT);
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [NUM_W-1:0] n);
        logic [NUM_W-1:0] diff;
        diff = n - NUM_W'(FIRST_NUMBER);
        return diff[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/descriptor_allocator_lifo_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Ports                       Transfer carries
// s_        in         s_valid, s_ready, s_item    op, desc_num, handle_in
// m_        out        m_valid, m_ready, m_item    status, desc_out, handle_out, std_stream
//
// Each transfer is accepted in S_IDLE, which issues the stack or table read; S_EXEC then
// finishes the read-modify-write of the handle table and loads the output register.
// Synchronous reset clears the stack count, free-stack flags and table valid bits.
// A new transfer is accepted while a result waits in the output register; the finishing
// cycle stalls only when that register is still full.

`include "descriptor_allocator_lifo_core_assert.svh"

module descriptor_allocator_lifo_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dal_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output dal_pkg::out_item_t m_item
);

    import dal_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     stack_count_reg, stack_count_next;
    logic [NUM_W-1:0]     fresh_reg, fresh_next;
    logic [CAPACITY-1:0]  on_free_reg, on_free_next;
    logic [CAPACITY-1:0]  hvalid_reg, hvalid_next;
    logic                 m_valid_reg, m_valid_next;

    op_t                  op_reg, op_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 pop_reg, pop_next;
    logic                 hit_reg, hit_next;
    logic [NUM_W-1:0]     grant_reg, grant_next;
    logic                 status_reg, status_next;
    logic [1:0]           stream_reg, stream_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    out_item_t            m_item_reg, m_item_next;

    logic                 st_we, st_re;
    logic [IDX_W-1:0]     st_waddr, st_raddr;
    logic [NUM_W-1:0]     st_wdata, st_rdata;
    logic                 ht_we, ht_re;
    logic [IDX_W-1:0]     ht_waddr, ht_raddr;
    logic [HANDLE_W-1:0]  ht_rdata;

    logic                 accept;
    logic                 out_free;
    logic [NUM_W-1:0]     granted;
    logic                 grant_ok;
    logic [IDX_W-1:0]     grant_idx;
    logic [IDX_W-1:0]     in_idx;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    assign in_idx    = to_idx(s_item.desc_num);
    assign granted   = pop_reg ? st_rdata : grant_reg;
    assign grant_ok  = in_range(granted);
    assign grant_idx = to_idx(granted);

    dal_ram #(
        .WIDTH (NUM_W),
        .DEPTH (CAPACITY)
    ) u_stack_ram (
        .clk   (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    dal_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (CAPACITY)
    ) u_table_ram (
        .clk   (aclk),
        .we    (ht_we),
        .waddr (ht_waddr),
        .wdata (handle_reg),
        .re    (ht_re),
        .raddr (ht_raddr),
        .rdata (ht_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        stack_count_next = stack_count_reg;
        fresh_next       = fresh_reg;
        on_free_next     = on_free_reg;
        hvalid_next      = hvalid_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        op_next          = op_reg;
        idx_next         = idx_reg;
        pop_next         = pop_reg;
        hit_next         = hit_reg;
        grant_next       = grant_reg;
        status_next      = status_reg;
        stream_next      = stream_reg;
        handle_next      = handle_reg;
        m_item_next      = m_item_reg;

        st_we    = 1'b0;
        st_waddr = stack_count_reg[IDX_W-1:0];
        st_wdata = s_item.desc_num;
        st_re    = 1'b0;
        st_raddr = IDX_W'(stack_count_reg - CNT_W'(1));
        ht_we    = 1'b0;
        ht_waddr = grant_idx;
        ht_re    = 1'b0;
        ht_raddr = in_idx;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next  = S_EXEC;
                    op_next     = s_item.op;
                    idx_next    = in_idx;
                    handle_next = s_item.handle_in;
                    pop_next    = 1'b0;
                    hit_next    = 1'b0;
                    grant_next  = '0;
                    status_next = STATUS_FAIL;
                    stream_next = STREAM_NONE;
                    case (s_item.op)
                        OP_ALLOC: begin
                            status_next = STATUS_OK;
                            if (stack_count_reg != '0) begin
                                stack_count_next = stack_count_reg - CNT_W'(1);
                                st_re            = 1'b1;
                                pop_next         = 1'b1;
                            end else if (int'(fresh_reg) < LIMIT) begin
                                grant_next = fresh_reg;
                                fresh_next = fresh_reg + NUM_W'(1);
                            end
                        end
                        OP_FREE: begin
                            if (in_range(s_item.desc_num)) begin
                                status_next         = STATUS_OK;
                                hvalid_next[in_idx] = 1'b0;
                                if (!on_free_reg[in_idx] &&
                                    (stack_count_reg < CNT_W'(CAPACITY))) begin
                                    st_we                = 1'b1;
                                    stack_count_next     = stack_count_reg + CNT_W'(1);
                                    on_free_next[in_idx] = 1'b1;
                                end
                            end
                        end
                        OP_LOOKUP: begin
                            if (s_item.desc_num <= NUM_W'(2)) begin
                                status_next = STATUS_OK;
                                stream_next = s_item.desc_num[1:0] + 2'd1;
                            end else if (in_range(s_item.desc_num)) begin
                                status_next = STATUS_OK;
                                ht_re       = 1'b1;
                                hit_next    = 1'b1;
                            end
                        end
                        default: begin
                            status_next = STATUS_FAIL;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next             = S_IDLE;
                    m_valid_next           = 1'b1;
                    m_item_next.status     = status_reg;
                    m_item_next.desc_out   = '0;
                    m_item_next.handle_out = '0;
                    m_item_next.std_stream = stream_reg;
                    if (op_reg == OP_ALLOC) begin
                        if (grant_ok) begin
                            ht_we                   = 1'b1;
                            hvalid_next[grant_idx]  = 1'b1;
                            on_free_next[grant_idx] = 1'b0;
                            m_item_next.desc_out    = granted;
                            m_item_next.status      = STATUS_OK;
                        end else begin
                            m_item_next.status = STATUS_FAIL;
                        end
                    end else if (hit_reg && hvalid_reg[idx_reg]) begin
                        m_item_next.handle_out = ht_rdata;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            stack_count_reg <= '0;
            fresh_reg       <= NUM_W'(FIRST_NUMBER);
            on_free_reg     <= '0;
            hvalid_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            stack_count_reg <= stack_count_next;
            fresh_reg       <= fresh_next;
            on_free_reg     <= on_free_next;
            hvalid_reg      <= hvalid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        pop_reg    <= pop_next;
        hit_reg    <= hit_next;
        grant_reg  <= grant_next;
        status_reg <= status_next;
        stream_reg <= stream_next;
        handle_reg <= handle_next;
        m_item_reg <= m_item_next;
    end

    `DAL_ASSERT(a_count_bound, aclk, aresetn, stack_count_reg <= CNT_W'(CAPACITY))
    `DAL_ASSERT(a_fresh_bound, aclk, aresetn, int'(fresh_reg) <= LIMIT)
    `DAL_ASSERT(a_accept_exec, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == S_EXEC))
    `DAL_ASSERT_NEVER(a_push_full, aclk, aresetn, st_we && (stack_count_reg == CNT_W'(CAPACITY)))

endmodule

`default_nettype wire

>>> hw/rtl/dal_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
